// ===== design/cwa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Centered window average: shared types and constants
// Field widths of the request and response beats, plus the fixed widths of
// the running sum and window counters.
// ----------------------------------------------------------------------------
package cwa_pkg;

   localparam int SAMPLE_W = 16;
   localparam int AVG_W    = 17;
   localparam int RADIUS_W = 6;
   localparam int CNT_W    = RADIUS_W + 1;
   localparam int SUM_W    = SAMPLE_W + CNT_W;

   localparam logic signed [AVG_W-1:0] NEG_ONE = '1;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                last_sample;
   } req_type;

   typedef struct packed {
      logic signed [AVG_W-1:0] average;
      logic                    last_result;
   } rsp_type;

endpackage

// ===== design/cwa_ring.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Centered window average: sample ring
// Simple dual-port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module cwa_ring #(
   parameter int ADDR_W = 7,
   parameter int DATA_W = 16
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   localparam int DEPTH = 1 << ADDR_W;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/cwa_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Centered window average: window sum divider
// Restoring radix-2 divider, one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module cwa_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [cwa_pkg::SUM_W-1:0] dividend,
   input  logic [cwa_pkg::CNT_W-1:0] divisor,
   output logic                      done,
   output logic [cwa_pkg::SUM_W-1:0] quotient
);

   import cwa_pkg::*;

   localparam int STEP_W = $clog2(SUM_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  div_ff, div_in;

   logic [CNT_W:0]    shifted_w;
   logic [CNT_W:0]    diff_w;
   logic              fits_w;

   // The partial remainder stays below the divisor, so it fits in CNT_W bits.
   assign shifted_w = {rem_ff, quo_ff[SUM_W-1]};
   assign diff_w    = shifted_w - {1'b0, div_ff};
   assign fits_w    = shifted_w >= {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = fits_w ? diff_w[CNT_W-1:0] : shifted_w[CNT_W-1:0];
         quo_in  = {quo_ff[SUM_W-2:0], fits_w};
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      div_ff  <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== design/centered_window_average.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Centered window average
// Streams unsigned samples and returns, per position, the truncated mean of
// the 2k+1 samples centered on it, or -1 where the window is incomplete.
//
//   Channel  Direction  Handshake        Beat contents
//   req_     in         valid / stall    sample, last_sample
//   rsp_     out        valid / stall    average, last_result
//   csr_     in         valid / ready    radius (write only)
//
// A sample that yields a full-window mean passes from accept through the ring
// read and sum update, 23 divider steps (one per sum bit), taking the quotient
// and the response load. A leading -1 goes from the sum update straight to the
// response load, and a sample with no result goes from the sum update to the
// flush state. Each trailing -1 after the last sample is loaded from the flush
// state, after any result of that sample's own. The next request is taken
// once the current one has placed all its results in the response register.
// Reset is synchronous; no clearing pass is needed since the ring is only read
// at slots written earlier in the same stream. A stalled response holds the
// sequencer until its register frees up.
// ----------------------------------------------------------------------------
module centered_window_average #(
   parameter int MAX_RADIUS  = 63,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  cwa_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output cwa_pkg::rsp_type             rsp_data,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [cwa_pkg::RADIUS_W-1:0] csr_data
);

   import cwa_pkg::*;

   // The ring must be deeper than the widest window so that the slot being
   // written never coincides with the slot leaving the window.
   localparam int RING_AW   = $clog2(2 * MAX_RADIUS + 2);
   localparam int USED_BITS = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = {SAMPLE_W{1'b1}} >> (SAMPLE_W - USED_BITS);
   localparam logic [RADIUS_W-1:0] MAX_K = RADIUS_W'(MAX_RADIUS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_DIV,
      ST_EMIT,
      ST_FLUSH
   } state_type;

   state_type               state_ff, state_in;
   logic [RADIUS_W-1:0]     radius_ff, radius_in;
   logic [RING_AW-1:0]      wp_ff, wp_in;
   logic [CNT_W-1:0]        seen_ff, seen_in;
   logic [SUM_W-1:0]        sum_ff, sum_in;
   logic [SAMPLE_W-1:0]     sample_ff, sample_in;
   logic                    last_ff, last_in;
   logic [CNT_W-1:0]        before_ff, before_in;
   logic                    full_ff, full_in;
   logic [RADIUS_W-1:0]     flush_ff, flush_in;
   logic signed [AVG_W-1:0] avg_ff, avg_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   logic [RADIUS_W-1:0]     k_w;
   logic [CNT_W-1:0]        width_w;
   logic [CNT_W-1:0]        twok_w;
   logic                    accept_w;
   logic                    out_free_w;
   logic [SAMPLE_W-1:0]     masked_w;
   logic [SAMPLE_W-1:0]     ring_rdata;
   logic                    ring_we;
   logic                    ring_re;
   logic [RING_AW-1:0]      rd_addr_w;
   logic [SAMPLE_W-1:0]     old_w;
   logic [SUM_W-1:0]        sum_new_w;
   logic [CNT_W:0]          before_inc_w;
   logic [CNT_W-1:0]        total_w;
   logic [CNT_W-1:0]        rest_raw_w;
   logic [RADIUS_W-1:0]     rest_w;
   logic                    lead_w;
   logic                    fullwin_w;
   logic                    div_start;
   logic                    div_done;
   logic [SUM_W-1:0]        div_quotient;

   assign k_w        = (radius_ff > MAX_K) ? MAX_K : radius_ff;
   assign width_w    = {k_w, 1'b1};
   assign twok_w     = {k_w, 1'b0};
   assign accept_w   = req_valid && !req_stall;
   assign out_free_w = !rsp_valid_ff || !rsp_stall;
   assign masked_w   = req_data.sample & SAMPLE_MASK;
   assign rd_addr_w  = wp_ff - width_w[RING_AW-1:0];

   // Sum update and end-of-stream bookkeeping, evaluated in ST_SUM.
   assign old_w        = full_ff ? ring_rdata : '0;
   assign sum_new_w    = sum_ff - SUM_W'(old_w) + SUM_W'(sample_ff);
   assign before_inc_w = {1'b0, before_ff} + 1'b1;
   assign total_w      = (before_inc_w >= {1'b0, width_w}) ? width_w
                                                          : before_inc_w[CNT_W-1:0];
   assign rest_raw_w   = (total_w > {1'b0, k_w}) ? (total_w - {1'b0, k_w}) : '0;
   assign rest_w       = !last_ff ? '0
                       : (rest_raw_w > {1'b0, k_w}) ? k_w : rest_raw_w[RADIUS_W-1:0];
   assign lead_w       = before_ff < {1'b0, k_w};
   assign fullwin_w    = before_ff >= twok_w;

   cwa_ring #(
      .ADDR_W (RING_AW),
      .DATA_W (SAMPLE_W)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (wp_ff),
      .wr_data (masked_w),
      .rd_en   (ring_re),
      .rd_addr (rd_addr_w),
      .rd_data (ring_rdata)
   );

   cwa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_new_w),
      .divisor  (width_w),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      state_in     = state_ff;
      radius_in    = radius_ff;
      wp_in        = wp_ff;
      seen_in      = seen_ff;
      sum_in       = sum_ff;
      sample_in    = sample_ff;
      last_in      = last_ff;
      before_in    = before_ff;
      full_in      = full_ff;
      flush_in     = flush_ff;
      avg_in       = avg_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      ring_we      = 1'b0;
      ring_re      = 1'b0;
      div_start    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (csr_valid) begin
               // A new radius starts a fresh stream.
               radius_in = csr_data;
               wp_in     = '0;
               seen_in   = '0;
               sum_in    = '0;
            end else if (accept_w) begin
               sample_in = masked_w;
               last_in   = req_data.last_sample;
               before_in = seen_ff;
               full_in   = seen_ff >= width_w;
               ring_we   = 1'b1;
               ring_re   = 1'b1;
               state_in  = ST_SUM;
            end
         end
         ST_SUM: begin
            flush_in = rest_w;
            if (last_ff) begin
               wp_in   = '0;
               seen_in = '0;
               sum_in  = '0;
            end else begin
               wp_in   = wp_ff + 1'b1;
               seen_in = total_w;
               sum_in  = sum_new_w;
            end
            if (lead_w) begin
               avg_in   = NEG_ONE;
               state_in = ST_EMIT;
            end else if (fullwin_w) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end else begin
               state_in = ST_FLUSH;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               avg_in   = {1'b0, div_quotient[SAMPLE_W-1:0]};
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free_w) begin
               rsp_valid_in       = 1'b1;
               rsp_in.average     = avg_ff;
               rsp_in.last_result = last_ff && (flush_ff == '0);
               state_in           = (flush_ff == '0) ? ST_IDLE : ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (flush_ff == '0) begin
               state_in = ST_IDLE;
            end else if (out_free_w) begin
               rsp_valid_in       = 1'b1;
               rsp_in.average     = NEG_ONE;
               rsp_in.last_result = last_ff && (flush_ff == RADIUS_W'(1));
               flush_in           = flush_ff - 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         radius_ff    <= RADIUS_W'(1);
         wp_ff        <= '0;
         seen_ff      <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         radius_ff    <= radius_in;
         wp_ff        <= wp_in;
         seen_ff      <= seen_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sample_ff <= sample_in;
      last_ff   <= last_in;
      before_ff <= before_in;
      full_ff   <= full_in;
      flush_ff  <= flush_in;
      avg_ff    <= avg_in;
      rsp_ff    <= rsp_in;
   end

   assign req_stall = (state_ff != ST_IDLE) || csr_valid;
   assign csr_ready = state_ff == ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_seen_bounded: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= width_w)
      else $error("sample count ran past the window width");

   a_accept_to_sum: assert property (@(posedge clock) disable iff (reset)
      accept_w |=> state_ff == ST_SUM)
      else $error("accepted beat did not move on to the sum update");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider finished while the sequencer was not waiting");

   a_stream_restart: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUM && last_ff) |=> (seen_ff == '0 && sum_ff == '0 && wp_ff == '0))
      else $error("stream state not cleared after the last sample");

   a_flush_bounded: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FLUSH |-> flush_ff <= k_w)
      else $error("trailing flush count exceeds the radius");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Centered window average testbench
// A short directed table covers the reset radius, zero and full radius, the
// sample extremes, short streams, end-of-stream flushing and a radius write
// that cuts a stream. A long stream of near-full-scale samples with no idle
// cycles follows, then random streams. Every response beat is checked in order
// against a typed row's beat or a cycle-free model of the running window.
// ----------------------------------------------------------------------------
module tb;
   import cwa_pkg::*;

   localparam int LIMIT_CYCLES  = 200000;
   localparam int SETTLE_CYCLES = 40;
   localparam int RANDOM_ITEMS  = 40;
   localparam int GAP_PERCENT   = 12;
   localparam int WIDE_STREAM   = 50;

   typedef enum logic {ROW_RADIUS, ROW_SAMPLE} row_kind_type;

   typedef struct packed {
      row_kind_type        kind;
      logic [SAMPLE_W-1:0] value;
      logic                last;
      logic                typed;
      rsp_type             want;
   } plan_row_type;

   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   req_type             req_data  = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   rsp_type             rsp_data;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [RADIUS_W-1:0] csr_data  = '0;

   // Window model state.
   logic [SAMPLE_W-1:0] ring_mem [128];
   logic [6:0]          ring_wr;
   int unsigned         taken;
   logic [SUM_W-1:0]    run_total;
   logic [RADIUS_W-1:0] half_width;

   plan_row_type plan [$];
   rsp_type      avg_expect_q [$];
   rsp_type      fresh_q [$];
   int           fault_count   = 0;
   int           checked_count = 0;
   int           sample_count  = 0;
   int           stream_count  = 0;
   int           radius_writes = 0;
   int unsigned  cycle_count   = 0;
   logic         steady        = 1'b0;

   centered_window_average dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   function automatic bit take_gap();
      return !steady && ($urandom_range(0, 99) < GAP_PERCENT);
   endfunction

   always @(negedge clock) begin
      rsp_stall <= take_gap();
   end

   always @(posedge clock) begin : watch_rsp
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (avg_expect_q.size() == 0) begin
            fault_count++;
            $display("%0t: result beat with nothing expected, average %0d last %0b",
                     $time, $signed(rsp_data.average), rsp_data.last_result);
         end else begin
            want = avg_expect_q.pop_front();
            checked_count++;
            if (rsp_data.average !== want.average) begin
               fault_count++;
               $display("%0t: average expected %0d got %0d", $time,
                        $signed(want.average), $signed(rsp_data.average));
            end
            if (rsp_data.last_result !== want.last_result) begin
               fault_count++;
               $display("%0t: last_result expected %0b got %0b", $time,
                        want.last_result, rsp_data.last_result);
            end
         end
      end
   end

   function automatic void restart_window();
      ring_wr   = '0;
      taken     = 0;
      run_total = '0;
   endfunction

   function automatic void note(input logic signed [AVG_W-1:0] avg, input logic fin);
      rsp_type r;
      r.average     = avg;
      r.last_result = fin;
      fresh_q.push_back(r);
   endfunction

   // Updates the running window with one sample and leaves the result beats
   // that it causes in fresh_q.
   function automatic void predict_window(input req_type d);
      int unsigned k, span, prior, tail, j;
      logic [6:0]  drop_slot;
      rsp_type     r;
      k     = half_width;
      span  = 2 * k + 1;
      prior = taken;
      fresh_q.delete();
      if (prior >= span) begin
         drop_slot = ring_wr - 7'(span);
         run_total = run_total - ring_mem[drop_slot];
      end
      ring_mem[ring_wr] = d.sample;
      run_total = run_total + d.sample;
      ring_wr   = ring_wr + 1'b1;
      taken     = (prior + 1 >= span) ? span : prior + 1;
      if (prior < k)
         note(NEG_ONE, 1'b0);
      else if (prior >= 2 * k)
         note(AVG_W'(run_total / span), 1'b0);
      if (d.last_sample) begin
         // Trailing positions never see a full window, so they flush as -1.
         if (taken > k) begin
            tail = taken - k;
            if (tail > k)
               tail = k;
            for (j = 0; j < tail; j++)
               note(NEG_ONE, 1'b0);
         end
         r = fresh_q[fresh_q.size() - 1];
         r.last_result = 1'b1;
         fresh_q[fresh_q.size() - 1] = r;
         restart_window();
      end
   endfunction

   function automatic void add_row(input row_kind_type kind, input logic [SAMPLE_W-1:0] value,
                                   input logic last, input logic typed,
                                   input logic signed [AVG_W-1:0] avg, input logic fin);
      plan_row_type row;
      row.kind             = kind;
      row.value            = value;
      row.last             = last;
      row.typed            = typed;
      row.want.average     = avg;
      row.want.last_result = fin;
      plan.push_back(row);
   endfunction

   task automatic drive_sample(input logic [SAMPLE_W-1:0] value, input logic last,
                               input logic typed, input rsp_type want);
      req_type beat;
      beat.sample      = value;
      beat.last_sample = last;
      @(negedge clock);
      while (take_gap()) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (req_stall);
      predict_window(beat);
      if (typed) begin
         fresh_q.delete();
         fresh_q.push_back(want);
      end
      foreach (fresh_q[i])
         avg_expect_q.push_back(fresh_q[i]);
      sample_count++;
      if (last)
         stream_count++;
   endtask

   // The radius is only written once the block has drained; a sample with no
   // result may still be in flight after the last beat, hence the settle time.
   task automatic write_radius(input logic [RADIUS_W-1:0] value);
      @(negedge clock);
      req_valid <= 1'b0;
      while (avg_expect_q.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      half_width = value;
      restart_window();
      radius_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int unsigned k, len, pick, random_items, i, j;
      logic        broken;

      // Radius comes out of reset as 1.
      add_row(ROW_SAMPLE, 16'h0000, 1'b0, 1'b1, NEG_ONE, 1'b0);
      add_row(ROW_SAMPLE, 16'hFFFF, 1'b0, 1'b0, '0, 1'b0);
      add_row(ROW_SAMPLE, 16'hFFFF, 1'b1, 1'b0, '0, 1'b0);
      // Zero radius passes every sample straight through.
      add_row(ROW_RADIUS, 16'd0, 1'b0, 1'b0, '0, 1'b0);
      add_row(ROW_SAMPLE, 16'hFFFF, 1'b0, 1'b1, 17'sd65535, 1'b0);
      add_row(ROW_SAMPLE, 16'h0000, 1'b1, 1'b1, 17'sd0, 1'b1);
      // Largest radius with a stream far too short for any mean.
      add_row(ROW_RADIUS, 16'd63, 1'b0, 1'b0, '0, 1'b0);
      add_row(ROW_SAMPLE, 16'h1234, 1'b0, 1'b1, NEG_ONE, 1'b0);
      add_row(ROW_SAMPLE, 16'hFFFF, 1'b1, 1'b1, NEG_ONE, 1'b1);
      add_row(ROW_RADIUS, 16'd2, 1'b0, 1'b0, '0, 1'b0);
      add_row(ROW_SAMPLE, 16'd10, 1'b0, 1'b1, NEG_ONE, 1'b0);
      add_row(ROW_SAMPLE, 16'd20, 1'b0, 1'b1, NEG_ONE, 1'b0);
      add_row(ROW_SAMPLE, 16'd30, 1'b0, 1'b0, '0, 1'b0);
      add_row(ROW_SAMPLE, 16'd40, 1'b0, 1'b0, '0, 1'b0);
      add_row(ROW_SAMPLE, 16'd50, 1'b1, 1'b0, '0, 1'b0);
      // A stream cut short by a radius write.
      add_row(ROW_SAMPLE, 16'd7, 1'b0, 1'b0, '0, 1'b0);
      add_row(ROW_SAMPLE, 16'd8, 1'b0, 1'b0, '0, 1'b0);
      add_row(ROW_SAMPLE, 16'd9, 1'b0, 1'b0, '0, 1'b0);
      add_row(ROW_RADIUS, 16'd3, 1'b0, 1'b0, '0, 1'b0);
      // Stream exactly as long as the radius, then one just past it.
      add_row(ROW_SAMPLE, 16'd1, 1'b0, 1'b1, NEG_ONE, 1'b0);
      add_row(ROW_SAMPLE, 16'd2, 1'b0, 1'b1, NEG_ONE, 1'b0);
      add_row(ROW_SAMPLE, 16'h5555, 1'b1, 1'b1, NEG_ONE, 1'b1);
      add_row(ROW_SAMPLE, 16'hAAAA, 1'b0, 1'b0, '0, 1'b0);
      add_row(ROW_SAMPLE, 16'd3, 1'b0, 1'b0, '0, 1'b0);
      add_row(ROW_SAMPLE, 16'd4, 1'b0, 1'b0, '0, 1'b0);
      add_row(ROW_SAMPLE, 16'd5, 1'b1, 1'b0, '0, 1'b0);

      repeat (9) @(negedge clock);
      reset <= 1'b0;
      half_width = RADIUS_W'(1);
      restart_window();

      foreach (plan[n]) begin
         if (plan[n].kind == ROW_RADIUS)
            write_radius(plan[n].value[RADIUS_W-1:0]);
         else
            drive_sample(plan[n].value, plan[n].last, plan[n].typed, plan[n].want);
      end

      // Near-full-scale samples at a wide window, with neither side idling.
      write_radius(6'd20);
      steady = 1'b1;
      for (i = 0; i < WIDE_STREAM; i++)
         drive_sample(($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'hFFFF,
                      i == WIDE_STREAM - 1, 1'b0, '0);
      steady = 1'b0;

      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 9);
         if (pick < 6)
            k = pick;
         else if (pick < 9)
            k = $urandom_range(7, 20);
         else
            k = $urandom_range(21, 63);
         write_radius(k[RADIUS_W-1:0]);
         repeat ($urandom_range(1, 3)) begin
            len    = $urandom_range(1, (4 * k + 3 > 40) ? 40 : 4 * k + 3);
            broken = ($urandom_range(0, 4) == 0);
            for (j = 0; j < len && random_items < RANDOM_ITEMS; j++) begin
               drive_sample(($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom),
                            (j == len - 1) && !broken, 1'b0, '0);
               random_items++;
            end
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (avg_expect_q.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("tb: %0d samples sent, %0d streams closed, %0d radius writes",
               sample_count, stream_count, radius_writes);
      $display("tb: %0d result beats compared, %0d mismatches", checked_count, fault_count);
      if (fault_count == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule

// ===== sim.f =====
design/cwa_pkg.sv
design/cwa_ring.sv
design/cwa_div.sv
design/centered_window_average.sv
bench/tb.sv
